// File: hw/rtl/pfp_pkg.sv
// Shared types, codes and constants for the publish/subscribe frame parser.
`default_nettype none

package pfp_pkg;

  localparam int LENGTH_BITS_DEFAULT = 16;
  localparam int FIELD_LEN_W         = 16;
  localparam int MAX_LEN_W           = 16;
  localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RESET = 16'd1024;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_U    = 8'h75;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_B    = 8'h62;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [1:0] TAG_NONE  = 2'd0;
  localparam logic [1:0] TAG_ID    = 2'd1;
  localparam logic [1:0] TAG_TOPIC = 2'd2;
  localparam logic [1:0] TAG_BODY  = 2'd3;

  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_MSG     = 2'd1;
  localparam logic [1:0] KIND_SUB     = 2'd2;
  localparam logic [1:0] KIND_UNSUB   = 2'd3;

  localparam logic [1:0] PHASE_PARSING = 2'd0;
  localparam logic [1:0] PHASE_DONE    = 2'd1;
  localparam logic [1:0] PHASE_ERROR   = 2'd2;

  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_SYNTAX   = 2'd1;
  localparam logic [1:0] VERDICT_TOO_LONG = 2'd2;

  typedef enum logic [4:0] {
    PS_WAIT_HASH   = 5'd0,
    PS_TYPE        = 5'd1,
    PS_M           = 5'd2,
    PS_MS          = 5'd3,
    PS_S           = 5'd4,
    PS_SU          = 5'd5,
    PS_U           = 5'd6,
    PS_UN          = 5'd7,
    PS_UNS         = 5'd8,
    PS_UNSU        = 5'd9,
    PS_TYPE_END    = 5'd10,
    PS_ID_FIRST    = 5'd11,
    PS_ID          = 5'd12,
    PS_TOPIC_FIRST = 5'd13,
    PS_TOPIC       = 5'd14,
    PS_BODY_FIRST  = 5'd15,
    PS_BODY        = 5'd16
  } parse_state_t;

  typedef struct packed {
    parse_state_t parse_state;
    logic [1:0]   kind;
    logic         error_flag;
    logic         done_flag;
  } frame_ctrl_t;

  localparam frame_ctrl_t CTRL_RESET = '{
    parse_state: PS_WAIT_HASH,
    kind:        KIND_UNKNOWN,
    error_flag:  1'b0,
    done_flag:   1'b0
  };

  typedef struct packed {
    logic [7:0]             byte_out;
    logic [1:0]             field_tag;
    logic                   field_end;
    logic [FIELD_LEN_W-1:0] field_length;
    logic [1:0]             msg_kind;
    logic [1:0]             phase;
    logic                   last_out;
    logic [1:0]             verdict;
    logic                   complete;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pfp_step.sv
// One parse step: next frame state and the result item for one input byte.
`default_nettype none

module pfp_step #(
  parameter int LENGTH_BITS = pfp_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire pfp_pkg::frame_ctrl_t           ctrl,
  input  wire logic [LENGTH_BITS-1:0]         pos,
  input  wire logic [LENGTH_BITS-1:0]         fstart,
  input  wire logic [pfp_pkg::MAX_LEN_W-1:0]  max_length,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           last,
  output pfp_pkg::frame_ctrl_t                ctrl_next,
  output logic [LENGTH_BITS-1:0]              pos_next,
  output logic [LENGTH_BITS-1:0]              fstart_next,
  output pfp_pkg::result_t                    result
);

  localparam int CMP_W = (LENGTH_BITS > pfp_pkg::MAX_LEN_W) ? LENGTH_BITS
                                                            : pfp_pkg::MAX_LEN_W;
  localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

  logic                   is_hash;
  logic                   is_space;
  logic [7:0]             lower;
  logic [LENGTH_BITS-1:0] diff;
  pfp_pkg::frame_ctrl_t   st;
  logic [1:0]             tag;
  logic                   fend;
  logic                   too_long;

  assign is_hash  = (data_byte == pfp_pkg::CH_HASH);
  assign is_space = (data_byte == pfp_pkg::CH_SPACE) ||
                    ((data_byte >= pfp_pkg::CH_TAB) && (data_byte <= pfp_pkg::CH_CR));
  assign lower    = ((data_byte >= pfp_pkg::CH_UPPER_A) && (data_byte <= pfp_pkg::CH_UPPER_Z))
                    ? data_byte + pfp_pkg::CASE_OFFSET : data_byte;
  assign diff     = pos - fstart;
  assign too_long = CMP_W'(pos) >= CMP_W'(max_length);

  always_comb begin
    st          = ctrl;
    tag         = pfp_pkg::TAG_NONE;
    fend        = 1'b0;
    fstart_next = fstart;
    if (!ctrl.error_flag && !ctrl.done_flag) begin
      unique case (ctrl.parse_state)
        pfp_pkg::PS_WAIT_HASH: begin
          if (is_hash) st.parse_state = pfp_pkg::PS_TYPE;
          else if (!is_space) st.error_flag = 1'b1;
        end
        pfp_pkg::PS_TYPE: begin
          if (lower == pfp_pkg::CH_M) st.parse_state = pfp_pkg::PS_M;
          else if (lower == pfp_pkg::CH_S) st.parse_state = pfp_pkg::PS_S;
          else if (lower == pfp_pkg::CH_U) st.parse_state = pfp_pkg::PS_U;
          else st.error_flag = 1'b1;
        end
        pfp_pkg::PS_M: begin
          if (lower == pfp_pkg::CH_S) st.parse_state = pfp_pkg::PS_MS;
          else st.error_flag = 1'b1;
        end
        pfp_pkg::PS_MS: begin
          if (lower == pfp_pkg::CH_G) begin
            st.parse_state = pfp_pkg::PS_TYPE_END;
            st.kind        = pfp_pkg::KIND_MSG;
          end else st.error_flag = 1'b1;
        end
        pfp_pkg::PS_S: begin
          if (lower == pfp_pkg::CH_U) st.parse_state = pfp_pkg::PS_SU;
          else st.error_flag = 1'b1;
        end
        pfp_pkg::PS_SU: begin
          if (lower == pfp_pkg::CH_B) begin
            st.parse_state = pfp_pkg::PS_TYPE_END;
            st.kind        = pfp_pkg::KIND_SUB;
          end else st.error_flag = 1'b1;
        end
        pfp_pkg::PS_U: begin
          if (lower == pfp_pkg::CH_N) st.parse_state = pfp_pkg::PS_UN;
          else st.error_flag = 1'b1;
        end
        pfp_pkg::PS_UN: begin
          if (lower == pfp_pkg::CH_S) st.parse_state = pfp_pkg::PS_UNS;
          else st.error_flag = 1'b1;
        end
        pfp_pkg::PS_UNS: begin
          if (lower == pfp_pkg::CH_U) st.parse_state = pfp_pkg::PS_UNSU;
          else st.error_flag = 1'b1;
        end
        pfp_pkg::PS_UNSU: begin
          if (lower == pfp_pkg::CH_B) begin
            st.parse_state = pfp_pkg::PS_TYPE_END;
            st.kind        = pfp_pkg::KIND_UNSUB;
          end else st.error_flag = 1'b1;
        end
        pfp_pkg::PS_TYPE_END: begin
          if (is_hash) st.parse_state = pfp_pkg::PS_ID_FIRST;
          else st.error_flag = 1'b1;
        end
        pfp_pkg::PS_ID_FIRST: begin
          fstart_next    = pos;
          st.parse_state = pfp_pkg::PS_ID;
          if (is_hash) st.error_flag = 1'b1;
          else tag = pfp_pkg::TAG_ID;
        end
        pfp_pkg::PS_TOPIC_FIRST: begin
          fstart_next    = pos;
          st.parse_state = pfp_pkg::PS_TOPIC;
          if (is_hash) st.error_flag = 1'b1;
          else tag = pfp_pkg::TAG_TOPIC;
        end
        pfp_pkg::PS_BODY_FIRST: begin
          fstart_next    = pos;
          st.parse_state = pfp_pkg::PS_BODY;
          if (is_hash) st.error_flag = 1'b1;
          else tag = pfp_pkg::TAG_BODY;
        end
        pfp_pkg::PS_ID: begin
          if (is_hash) begin
            fend           = 1'b1;
            st.parse_state = pfp_pkg::PS_TOPIC_FIRST;
          end else tag = pfp_pkg::TAG_ID;
        end
        pfp_pkg::PS_TOPIC: begin
          if (is_hash) begin
            fend = 1'b1;
            if (ctrl.kind == pfp_pkg::KIND_MSG) st.parse_state = pfp_pkg::PS_BODY_FIRST;
            else st.done_flag = 1'b1;
          end else tag = pfp_pkg::TAG_TOPIC;
        end
        pfp_pkg::PS_BODY: begin
          if (is_hash) begin
            fend         = 1'b1;
            st.done_flag = 1'b1;
          end else tag = pfp_pkg::TAG_BODY;
        end
        default: st.error_flag = 1'b1;
      endcase
    end
  end

  always_comb begin
    result.byte_out     = data_byte;
    result.field_tag    = tag;
    result.field_end    = fend;
    result.field_length = fend ? pfp_pkg::FIELD_LEN_W'(diff) : '0;
    result.msg_kind     = st.kind;
    result.phase        = st.error_flag ? pfp_pkg::PHASE_ERROR :
                          (st.done_flag ? pfp_pkg::PHASE_DONE : pfp_pkg::PHASE_PARSING);
    result.last_out     = last;
    result.verdict      = !last ? pfp_pkg::VERDICT_OK :
                          (too_long ? pfp_pkg::VERDICT_TOO_LONG :
                          (st.error_flag ? pfp_pkg::VERDICT_SYNTAX : pfp_pkg::VERDICT_OK));
    result.complete     = st.done_flag;
  end

  // Clear the frame after the last byte; otherwise advance with saturation.
  always_comb begin
    if (last) begin
      ctrl_next = pfp_pkg::CTRL_RESET;
      pos_next  = '0;
    end else begin
      ctrl_next = st;
      pos_next  = (pos == POS_MAX) ? pos : pos + 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pubsub_frame_parser.sv
// Top level of the publish/subscribe frame parser: registers, handshake, checks.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_axis  | in  | s_tvalid/s_tready  | s_tdata: data_byte; s_tlast: last
//  m_axis  | out | m_tvalid/m_tready  | m_tdata/m_tuser: result; m_tlast: last_out
//  cfg     | in  | cfg_we             | cfg_wdata: max_length
//
// Each byte passes from acceptance into the input register, then through the
// parse step into the result register. While the output does not stall, a
// new byte is taken every cycle; throughput is one item per cycle, set by the
// single parse step between the two registers. When the output stalls, the
// input register holds one byte and s_tready drops until the result is taken.
// rst is synchronous; it clears the frame state and sets max_length to 1024.
`default_nettype none

module pubsub_frame_parser #(
  parameter int LENGTH_BITS = pfp_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        s_tvalid,
  output logic              s_tready,
  input  wire  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire  logic        s_tlast,   // last
  output logic              m_tvalid,
  input  wire  logic        m_tready,
  output logic [31:0]       m_tdata,   // [7:0] byte_out, [8] field_end,
                                       // [24:9] field_length, [26:25] phase,
                                       // [28:27] verdict, [29] complete, rest 0
  output logic [3:0]        m_tuser,   // [1:0] field_tag, [3:2] msg_kind
  output logic              m_tlast,   // last_out
  input  wire  logic        cfg_we,
  input  wire  logic [pfp_pkg::MAX_LEN_W-1:0] cfg_wdata  // max_length
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // frame state
  pfp_pkg::frame_ctrl_t     ctrl;
  pfp_pkg::frame_ctrl_t     ctrl_next;
  logic [LENGTH_BITS-1:0]   pos;
  logic [LENGTH_BITS-1:0]   pos_next;
  logic [LENGTH_BITS-1:0]   fstart;
  logic [LENGTH_BITS-1:0]   fstart_next;
  logic [pfp_pkg::MAX_LEN_W-1:0] max_length;

  // result register
  logic             out_valid;
  pfp_pkg::result_t out_res;
  pfp_pkg::result_t step_res;

  logic advance;

  // Move the held byte into the result register when that slot is free.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= pfp_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload: load on every accepted byte, no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  pfp_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .ctrl        (ctrl),
    .pos         (pos),
    .fstart      (fstart),
    .max_length  (max_length),
    .data_byte   (in_byte),
    .last        (in_last),
    .ctrl_next   (ctrl_next),
    .pos_next    (pos_next),
    .fstart_next (fstart_next),
    .result      (step_res)
  );

  // Advance frame state only when a byte leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl   <= pfp_pkg::CTRL_RESET;
      pos    <= '0;
      fstart <= '0;
    end else if (advance) begin
      ctrl   <= ctrl_next;
      pos    <= pos_next;
      fstart <= in_last ? '0 : fstart_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.last_out;
  assign m_tuser  = {out_res.msg_kind, out_res.field_tag};
  assign m_tdata  = {2'b00, out_res.complete, out_res.verdict, out_res.phase,
                     out_res.field_length, out_res.field_end, out_res.byte_out};

  // Error and finished can never both be set within one frame.
  a_err_done_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.error_flag && ctrl.done_flag))
    else $error("error and done flags both set");

  // A last byte leaves the frame state cleared for the next frame.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=>
      (ctrl.parse_state == pfp_pkg::PS_WAIT_HASH) && (pos == '0) && !ctrl.error_flag)
    else $error("frame state not cleared after last byte");

  // A closing hash is never tagged as field content.
  a_end_untagged: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.field_end) |-> (out_res.field_tag == pfp_pkg::TAG_NONE))
    else $error("field end carries a field tag");

  // A byte that advances always shows up as a pending result.
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced byte produced no result");

endmodule

`default_nettype wire
